// ===== hdl/twsg_pkg.sv =====
package twsg_pkg;

    // cordic datapath word, signed Q2.30 with headroom
    localparam int CW = 34;
    typedef logic signed [CW-1:0] t_cw;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CFG = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_TAN_SAT = 2'd3;

    // function select codes, anything else is tangent
    localparam logic [1:0] MODE_SIN = 2'd0;
    localparam logic [1:0] MODE_COS = 2'd1;

    // register indexes
    localparam logic [2:0] REG_FUNC_MODE    = 3'd0;
    localparam logic [2:0] REG_LINE_LENGTH  = 3'd1;
    localparam logic [2:0] REG_POINT_COUNT  = 3'd2;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
    localparam logic [2:0] REG_FREQUENCY    = 3'd4;
    localparam logic [2:0] REG_PHASE_OFFSET = 3'd5;
    localparam logic [2:0] REG_LEVEL_OFFSET = 3'd6;

    // 1/(2*pi) in Q0.64, split in halves
    localparam logic [31:0] INV_TWO_PI_LO = 32'h9391054A;
    localparam logic [31:0] INV_TWO_PI_HI = 32'h28BE60DB;
    // pi/2 in Q32
    localparam logic [32:0] HALF_PI_Q32   = 33'h1921FB544;
    // 1/K cordic gain in Q30
    localparam t_cw CORDIC_GAIN = t_cw'(652032874);

    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    // sideband of the index divider
    typedef struct packed {
        logic [1:0] status;
        logic       last;
    } t_dside;

    // sideband along the angle path
    typedef struct packed {
        logic [30:0] x;
        logic [1:0]  status;
        logic        last;
    } t_pside;

    typedef struct packed {
        logic [1:0] quad;
        t_pside     p;
    } t_cside;

    // sideband of the tangent divider
    typedef struct packed {
        t_cw    f;
        logic   tneg;
        logic   sn_neg;
        logic   cz;
        logic   ovf;
        t_pside p;
    } t_tside;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic [1:0]  status;
    } t_item;

    // arctangent of 2^-i in Q30
    function automatic t_cw cordic_atan(input int idx);
        t_cw v;
        case (idx)
            0:  v = t_cw'(843314857);
            1:  v = t_cw'(497837830);
            2:  v = t_cw'(263043837);
            3:  v = t_cw'(133525159);
            4:  v = t_cw'(67021687);
            5:  v = t_cw'(33543516);
            6:  v = t_cw'(16775851);
            7:  v = t_cw'(8388437);
            8:  v = t_cw'(4194283);
            9:  v = t_cw'(2097149);
            10: v = t_cw'(1048576);
            11: v = t_cw'(524288);
            12: v = t_cw'(262144);
            13: v = t_cw'(131072);
            14: v = t_cw'(65536);
            15: v = t_cw'(32768);
            16: v = t_cw'(16384);
            17: v = t_cw'(8192);
            18: v = t_cw'(4096);
            19: v = t_cw'(2048);
            20: v = t_cw'(1024);
            21: v = t_cw'(512);
            22: v = t_cw'(256);
            23: v = t_cw'(128);
            24: v = t_cw'(64);
            25: v = t_cw'(32);
            26: v = t_cw'(16);
            27: v = t_cw'(8);
            28: v = t_cw'(4);
            29: v = t_cw'(2);
            default: v = t_cw'(1);
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/twsg_div_cell.sv =====
module twsg_div_cell #(
    parameter int DW = 17,
    parameter int NW = 31,
    parameter int QW = 31,
    parameter int PW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [NW-1:0] i_num,
    input  logic [QW-1:0] i_quo,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [DW-1:0] o_rem,
    output logic [DW-1:0] o_div,
    output logic [NW-1:0] o_num,
    output logic [QW-1:0] o_quo,
    output logic [PW-1:0] o_side
);

    logic [DW:0]   w_trial;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic [DW-1:0] n_rem;

    // one restoring step: bring down a numerator bit, subtract if it fits
    always_comb begin
        w_trial = {i_rem, i_num[NW-1]};
        w_diff  = w_trial - {1'b0, i_div};
        w_ge    = (w_trial >= {1'b0, i_div});
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_div  <= i_div;
            o_num  <= {i_num[NW-2:0], 1'b0};
            o_quo  <= {i_quo[QW-2:0], w_ge};
            o_side <= i_side;
        end
    end

endmodule

// ===== hdl/twsg_cordic_cell.sv =====
module twsg_cordic_cell import twsg_pkg::*; #(
    parameter int STAGE = 0,
    parameter int PW    = 36
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  t_cw           i_x,
    input  t_cw           i_y,
    input  t_cw           i_z,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output t_cw           o_x,
    output t_cw           o_y,
    output t_cw           o_z,
    output logic [PW-1:0] o_side
);

    localparam t_cw ATAN = cordic_atan(STAGE);

    t_cw w_dx;
    t_cw w_dy;
    t_cw n_x;
    t_cw n_y;
    t_cw n_z;

    // rotate toward zero residual angle
    always_comb begin
        w_dx = i_y >>> STAGE;
        w_dy = i_x >>> STAGE;
        if (!i_z[CW-1]) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_side <= i_side;
        end
    end

endmodule

// ===== hdl/trig_waveform_sample_generator_core.sv =====
// channel | valid       | stall       | payload
// --------+-------------+-------------+---------------------------------------------
// in      | i_in_valid  | o_in_stall  | i_sample_index
// out     | o_out_valid | i_out_stall | o_x_coord, o_y_value, o_is_last, o_status
// config  | APB write/read, pready tied high, registers at 4*index
//
// one item per cycle while the skid entry is empty; from accept to o_out_valid an item
// passes the 31-cell index divider, the cordic row and the 32-cell tangent divider
// the output register plus one skid entry decouple the result side; a stall of the
// output freezes the whole pipe once the skid entry is full
// synchronous active-low reset clears valid bits and loads register defaults
module trig_waveform_sample_generator_core import twsg_pkg::*; #(
    parameter int MAX_POINTS   = 65536,
    parameter int ANGLE_STAGES = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_sample_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_x_coord,
    output logic [31:0] o_y_value,
    output logic        o_is_last,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int D1_N  = 31;
    localparam int D2_N  = 32;
    localparam int DPW   = $bits(t_dside);
    localparam int CPW   = $bits(t_cside);
    localparam int TPW   = $bits(t_tside);

    // ---------------- configuration registers ----------------
    logic [1:0]         r_func_mode;
    logic signed [31:0] r_len;
    logic [16:0]        r_pc;
    logic signed [31:0] r_amp;
    logic signed [31:0] r_freq;
    logic signed [31:0] r_phase;
    logic signed [31:0] r_level;
    logic               w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_mode <= MODE_SIN;
            r_len       <= 32'sd65536;
            r_pc        <= 17'd2;
            r_amp       <= 32'sd65536;
            r_freq      <= 32'sd65536;
            r_phase     <= 32'sd0;
            r_level     <= 32'sd0;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                REG_FUNC_MODE:    r_func_mode <= pwdata[1:0];
                REG_LINE_LENGTH:  r_len       <= pwdata;
                REG_POINT_COUNT:  r_pc        <= pwdata[16:0];
                REG_AMPLITUDE:    r_amp       <= pwdata;
                REG_FREQUENCY:    r_freq      <= pwdata;
                REG_PHASE_OFFSET: r_phase     <= pwdata;
                REG_LEVEL_OFFSET: r_level     <= pwdata;
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (paddr[4:2])
            REG_FUNC_MODE:    prdata = {30'd0, r_func_mode};
            REG_LINE_LENGTH:  prdata = r_len;
            REG_POINT_COUNT:  prdata = {15'd0, r_pc};
            REG_AMPLITUDE:    prdata = r_amp;
            REG_FREQUENCY:    prdata = r_freq;
            REG_PHASE_OFFSET: prdata = r_phase;
            REG_LEVEL_OFFSET: prdata = r_level;
            default:          prdata = 32'd0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic w_en;
    logic r_k_v;
    logic r_o_v;

    assign w_en       = !r_k_v;
    assign o_in_stall = r_k_v;

    // ---------------- stage 1: checks and index * length ----------------
    logic        r_s1_v;
    logic [46:0] r_s1_n;
    t_dside      r_s1_side;
    t_dside      w_s1_side;
    logic        w_bad;

    always_comb begin
        w_bad = (r_pc == 17'd0) || (32'(r_pc) > 32'(MAX_POINTS))
                || r_len[31] || (r_len == 32'sd0);
        w_s1_side.last = 1'b0;
        if (w_bad) begin
            w_s1_side.status = ST_BAD_CFG;
        end else if ({1'b0, i_sample_index} >= r_pc) begin
            w_s1_side.status = ST_RANGE;
        end else begin
            w_s1_side.status = ST_OK;
            w_s1_side.last   = ({1'b0, i_sample_index} == (r_pc - 17'd1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_n    <= 47'(i_sample_index) * 47'(r_len[30:0]);
            r_s1_side <= w_s1_side;
        end
    end

    // ---------------- index divider row ----------------
    logic            w_d1_v    [0:D1_N];
    logic [16:0]     w_d1_rem  [0:D1_N];
    logic [16:0]     w_d1_div  [0:D1_N];
    logic [30:0]     w_d1_num  [0:D1_N];
    logic [30:0]     w_d1_quo  [0:D1_N];
    logic [DPW-1:0]  w_d1_side [0:D1_N];

    assign w_d1_v[0]    = r_s1_v;
    assign w_d1_rem[0]  = {1'b0, r_s1_n[46:31]};
    assign w_d1_div[0]  = r_pc - 17'd1;
    assign w_d1_num[0]  = r_s1_n[30:0];
    assign w_d1_quo[0]  = 31'd0;
    assign w_d1_side[0] = r_s1_side;

    for (genvar g = 0; g < D1_N; g++) begin : g_div1
        twsg_div_cell #(.DW(17), .NW(31), .QW(31), .PW(DPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_d1_v[g]),
            .i_rem   (w_d1_rem[g]),
            .i_div   (w_d1_div[g]),
            .i_num   (w_d1_num[g]),
            .i_quo   (w_d1_quo[g]),
            .i_side  (w_d1_side[g]),
            .o_valid (w_d1_v[g+1]),
            .o_rem   (w_d1_rem[g+1]),
            .o_div   (w_d1_div[g+1]),
            .o_num   (w_d1_num[g+1]),
            .o_quo   (w_d1_quo[g+1]),
            .o_side  (w_d1_side[g+1])
        );
    end

    // ---------------- stages 2..8: angle and turn fraction ----------------
    logic               r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v, r_s7_v, r_s8_v;
    t_pside             r_s2_side, r_s3_side, r_s4_side, r_s5_side, r_s6_side;
    t_pside             r_s7_side;
    t_cside             r_s8_side;
    logic signed [63:0] r_s2_p;
    logic signed [63:0] r_s3_a;
    logic [63:0]        r_s4_m;
    logic               r_s4_neg, r_s5_neg, r_s6_neg;
    logic [63:0]        r_s5_p0, r_s5_p1, r_s5_p2, r_s5_p3;
    logic [33:0]        r_s6_mid;
    logic [31:0]        r_s6_s;
    logic [31:0]        r_s7_u;
    t_cw                r_s8_z;
    logic [30:0]        w_x_fin;
    t_dside             w_d1_out;
    logic [31:0]        w_u_pos;
    logic [62:0]        w_zp;

    assign w_d1_out = t_dside'(w_d1_side[D1_N]);
    // a single point sits at the origin
    assign w_x_fin  = (r_pc == 17'd1) ? 31'd0 : w_d1_quo[D1_N];
    assign w_u_pos  = r_s6_s + 32'(r_s6_mid[33:32]);
    assign w_zp     = 63'(r_s7_u[29:0]) * 63'(HALF_PI_Q32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
            r_s7_v <= 1'b0;
            r_s8_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= w_d1_v[D1_N];
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_s7_v <= r_s6_v;
            r_s8_v <= r_s7_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // frequency times x
            r_s2_p           <= r_freq * $signed({1'b0, w_x_fin});
            r_s2_side.x      <= w_x_fin;
            r_s2_side.status <= w_d1_out.status;
            r_s2_side.last   <= w_d1_out.last;
            // add phase in Q32.32
            r_s3_a    <= r_s2_p + $signed({{16{r_phase[31]}}, r_phase, 16'h0000});
            r_s3_side <= r_s2_side;
            // magnitude
            r_s4_neg  <= r_s3_a[63];
            r_s4_m    <= r_s3_a[63] ? 64'(-r_s3_a) : 64'(r_s3_a);
            r_s4_side <= r_s3_side;
            // partial products with 1/(2*pi)
            r_s5_p0   <= 64'(r_s4_m[31:0])  * 64'(INV_TWO_PI_LO);
            r_s5_p1   <= 64'(r_s4_m[31:0])  * 64'(INV_TWO_PI_HI);
            r_s5_p2   <= 64'(r_s4_m[63:32]) * 64'(INV_TWO_PI_LO);
            r_s5_p3   <= 64'(r_s4_m[63:32]) * 64'(INV_TWO_PI_HI);
            r_s5_neg  <= r_s4_neg;
            r_s5_side <= r_s4_side;
            // column sums
            r_s6_mid  <= 34'(r_s5_p0[63:32]) + 34'(r_s5_p1[31:0]) + 34'(r_s5_p2[31:0]);
            r_s6_s    <= r_s5_p3[31:0] + r_s5_p1[63:32] + r_s5_p2[63:32];
            r_s6_neg  <= r_s5_neg;
            r_s6_side <= r_s5_side;
            // turn fraction, mirrored for a negative angle
            r_s7_u    <= r_s6_neg ? (32'd0 - w_u_pos) : w_u_pos;
            r_s7_side <= r_s6_side;
            // residual angle within the quadrant
            r_s8_z         <= t_cw'({3'b000, w_zp[62:32]});
            r_s8_side.quad <= r_s7_u[31:30];
            r_s8_side.p    <= r_s7_side;
        end
    end

    // ---------------- cordic row ----------------
    logic           w_c_v    [0:ANGLE_STAGES];
    t_cw            w_c_x    [0:ANGLE_STAGES];
    t_cw            w_c_y    [0:ANGLE_STAGES];
    t_cw            w_c_z    [0:ANGLE_STAGES];
    logic [CPW-1:0] w_c_side [0:ANGLE_STAGES];

    assign w_c_v[0]    = r_s8_v;
    assign w_c_x[0]    = CORDIC_GAIN;
    assign w_c_y[0]    = t_cw'(0);
    assign w_c_z[0]    = r_s8_z;
    assign w_c_side[0] = r_s8_side;

    for (genvar g = 0; g < ANGLE_STAGES; g++) begin : g_cordic
        twsg_cordic_cell #(.STAGE(g), .PW(CPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_c_v[g]),
            .i_x     (w_c_x[g]),
            .i_y     (w_c_y[g]),
            .i_z     (w_c_z[g]),
            .i_side  (w_c_side[g]),
            .o_valid (w_c_v[g+1]),
            .o_x     (w_c_x[g+1]),
            .o_y     (w_c_y[g+1]),
            .o_z     (w_c_z[g+1]),
            .o_side  (w_c_side[g+1])
        );
    end

    // ---------------- stage 9: quadrant fold ----------------
    logic   r_s9_v;
    t_cw    r_s9_sn;
    t_cw    r_s9_cs;
    t_pside r_s9_side;
    t_cside w_c_out;
    t_cw    w_sn;
    t_cw    w_cs;

    assign w_c_out = t_cside'(w_c_side[ANGLE_STAGES]);

    always_comb begin
        case (w_c_out.quad)
            2'd0: begin
                w_sn = w_c_y[ANGLE_STAGES];
                w_cs = w_c_x[ANGLE_STAGES];
            end
            2'd1: begin
                w_sn = w_c_x[ANGLE_STAGES];
                w_cs = -w_c_y[ANGLE_STAGES];
            end
            2'd2: begin
                w_sn = -w_c_y[ANGLE_STAGES];
                w_cs = -w_c_x[ANGLE_STAGES];
            end
            default: begin
                w_sn = -w_c_x[ANGLE_STAGES];
                w_cs = w_c_y[ANGLE_STAGES];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s9_v <= 1'b0;
        end else if (w_en) begin
            r_s9_v <= w_c_v[ANGLE_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s9_sn   <= w_sn;
            r_s9_cs   <= w_cs;
            r_s9_side <= w_c_out.p;
        end
    end

    // ---------------- stage 10: magnitudes for the tangent ----------------
    logic        r_s10_v;
    logic [32:0] r_s10_sabs;
    logic [32:0] r_s10_cabs;
    t_tside      r_s10_side;
    t_cw         w_sabs_full;
    t_cw         w_cabs_full;
    t_tside      w_s10_side;

    always_comb begin
        w_sabs_full       = r_s9_sn[CW-1] ? -r_s9_sn : r_s9_sn;
        w_cabs_full       = r_s9_cs[CW-1] ? -r_s9_cs : r_s9_cs;
        w_s10_side.f      = (r_func_mode == MODE_SIN) ? r_s9_sn : r_s9_cs;
        w_s10_side.tneg   = r_s9_sn[CW-1] ^ r_s9_cs[CW-1];
        w_s10_side.sn_neg = r_s9_sn[CW-1];
        w_s10_side.cz     = (r_s9_cs == t_cw'(0));
        w_s10_side.ovf    = 1'b0;
        w_s10_side.p      = r_s9_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s10_v <= 1'b0;
        end else if (w_en) begin
            r_s10_v <= r_s9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s10_sabs <= w_sabs_full[32:0];
            r_s10_cabs <= w_cabs_full[32:0];
            r_s10_side <= w_s10_side;
        end
    end

    // ---------------- tangent divider row ----------------
    logic           w_d2_v    [0:D2_N];
    logic [32:0]    w_d2_rem  [0:D2_N];
    logic [32:0]    w_d2_div  [0:D2_N];
    logic [31:0]    w_d2_num  [0:D2_N];
    logic [31:0]    w_d2_quo  [0:D2_N];
    logic [TPW-1:0] w_d2_side [0:D2_N];
    t_tside         w_d2_in;

    // quotient of 2^32 or more shows up in the high part alone
    always_comb begin
        w_d2_in     = r_s10_side;
        w_d2_in.ovf = ({16'd0, r_s10_sabs[32:16]} >= r_s10_cabs);
    end

    assign w_d2_v[0]    = r_s10_v;
    assign w_d2_rem[0]  = {16'd0, r_s10_sabs[32:16]};
    assign w_d2_div[0]  = r_s10_cabs;
    assign w_d2_num[0]  = {r_s10_sabs[15:0], 16'h0000};
    assign w_d2_quo[0]  = 32'd0;
    assign w_d2_side[0] = w_d2_in;

    for (genvar g = 0; g < D2_N; g++) begin : g_div2
        twsg_div_cell #(.DW(33), .NW(32), .QW(32), .PW(TPW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_d2_v[g]),
            .i_rem   (w_d2_rem[g]),
            .i_div   (w_d2_div[g]),
            .i_num   (w_d2_num[g]),
            .i_quo   (w_d2_quo[g]),
            .i_side  (w_d2_side[g]),
            .o_valid (w_d2_v[g+1]),
            .o_rem   (w_d2_rem[g+1]),
            .o_div   (w_d2_div[g+1]),
            .o_num   (w_d2_num[g+1]),
            .o_quo   (w_d2_quo[g+1]),
            .o_side  (w_d2_side[g+1])
        );
    end

    // ---------------- stage 11: tangent clamp and operand select ----------------
    logic               r_s11_v;
    t_cw                r_s11_op;
    logic               r_s11_tan;
    logic               r_s11_sat;
    t_pside             r_s11_side;
    t_tside             w_t_side;
    logic [31:0]        w_q;
    logic signed [31:0] w_t;
    logic               w_sat;
    logic               w_tan;

    assign w_t_side = t_tside'(w_d2_side[D2_N]);
    assign w_q      = w_d2_quo[D2_N];
    assign w_tan    = (r_func_mode != MODE_SIN) && (r_func_mode != MODE_COS);

    always_comb begin
        if (w_t_side.cz) begin
            // pole: range end with the sign of the sine
            w_sat = 1'b1;
            w_t   = w_t_side.sn_neg ? S32_MIN : S32_MAX;
        end else if (!w_t_side.tneg) begin
            w_sat = w_t_side.ovf || w_q[31];
            w_t   = w_sat ? S32_MAX : $signed(w_q);
        end else begin
            w_sat = w_t_side.ovf || (w_q > 32'h80000000);
            w_t   = w_sat ? S32_MIN : $signed(32'd0 - w_q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s11_v <= 1'b0;
        end else if (w_en) begin
            r_s11_v <= w_d2_v[D2_N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s11_op   <= w_tan ? t_cw'(w_t) : w_t_side.f;
            r_s11_tan  <= w_tan;
            r_s11_sat  <= w_sat;
            r_s11_side <= w_t_side.p;
        end
    end

    // ---------------- stage 12: amplitude multiply ----------------
    logic               r_s12_v;
    logic signed [65:0] r_s12_prod;
    logic               r_s12_tan;
    logic               r_s12_sat;
    t_pside             r_s12_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s12_v <= 1'b0;
        end else if (w_en) begin
            r_s12_v <= r_s11_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s12_prod <= r_amp * r_s11_op;
            r_s12_tan  <= r_s11_tan;
            r_s12_sat  <= r_s11_sat;
            r_s12_side <= r_s11_side;
        end
    end

    // ---------------- stage 13: scale, offset, saturate, assemble ----------------
    logic               r_s13_v;
    t_item              r_s13_item;
    logic signed [65:0] w_shifted;
    logic signed [65:0] w_sum;
    logic signed [31:0] w_y;
    t_item              w_item;

    always_comb begin
        w_shifted = r_s12_tan ? (r_s12_prod >>> 16) : (r_s12_prod >>> 30);
        w_sum     = w_shifted + $signed({{34{r_level[31]}}, r_level});
        if (w_sum > 66'sd2147483647) begin
            w_y = S32_MAX;
        end else if (w_sum < -66'sd2147483648) begin
            w_y = S32_MIN;
        end else begin
            w_y = w_sum[31:0];
        end
        if (r_s12_side.status != ST_OK) begin
            w_item.x      = 32'd0;
            w_item.y      = 32'd0;
            w_item.last   = 1'b0;
            w_item.status = r_s12_side.status;
        end else begin
            w_item.x      = {1'b0, r_s12_side.x};
            w_item.y      = w_y;
            w_item.last   = r_s12_side.last;
            w_item.status = (r_s12_tan && r_s12_sat) ? ST_TAN_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s13_v <= 1'b0;
        end else if (w_en) begin
            r_s13_v <= r_s12_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s13_item <= w_item;
        end
    end

    // ---------------- output register and skid entry ----------------
    t_item r_o_item;
    t_item r_k_item;
    logic  w_o_free;

    assign w_o_free = !r_o_v || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
            r_k_v <= 1'b0;
        end else if (r_k_v) begin
            if (w_o_free) begin
                r_o_v <= 1'b1;
                r_k_v <= 1'b0;
            end
        end else if (r_s13_v) begin
            if (w_o_free) begin
                r_o_v <= 1'b1;
            end else begin
                r_k_v <= 1'b1;
            end
        end else if (w_o_free) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_k_v) begin
            if (w_o_free) begin
                r_o_item <= r_k_item;
            end
        end else if (r_s13_v) begin
            if (w_o_free) begin
                r_o_item <= r_s13_item;
            end else begin
                r_k_item <= r_s13_item;
            end
        end
    end

    assign o_out_valid = r_o_v;
    assign o_x_coord   = r_o_item.x;
    assign o_y_value   = r_o_item.y;
    assign o_is_last   = r_o_item.last;
    assign o_status    = r_o_item.status;

    // ---------------- assertions ----------------
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k_v |-> r_o_v)
        else $error("skid entry full while output register empty");

    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k_v && r_o_v && i_out_stall) |=> (r_k_v && $stable(r_k_item)))
        else $error("skid entry lost while output stalled");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && (r_o_item.status == ST_BAD_CFG || r_o_item.status == ST_RANGE))
        |-> (r_o_item.x == 32'd0 && r_o_item.y == 32'd0 && !r_o_item.last))
        else $error("error item carries nonzero fields");

    a_skid_fills_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_k_v && r_s13_v && r_o_v && i_out_stall) |=> r_k_v)
        else $error("finished item dropped on output stall");

endmodule

// ===== dv/testbench.sv =====
module testbench import twsg_pkg::*;;

    // one expected sample point
    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic        last;
        logic [1:0]  status;
    } t_point;

    localparam int PIPE_DEPTH = 24 + 77;

    // scoreboard: predicts sample points and checks the block's results
    class point_board;
        logic [1:0]  mode;
        logic [31:0] length;
        logic [16:0] npoints;
        logic [31:0] alpha;
        logic [31:0] beta;
        logic [31:0] gamma;
        logic [31:0] delta;
        t_point      pending[$];
        int          errors;

        function void load_defaults();
            mode = MODE_SIN;
            length = 32'd65536;
            npoints = 17'd2;
            alpha = 32'd65536;
            beta = 32'd65536;
            gamma = 32'd0;
            delta = 32'd0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_FUNC_MODE:    mode = v[1:0];
                REG_LINE_LENGTH:  length = v;
                REG_POINT_COUNT:  npoints = v[16:0];
                REG_AMPLITUDE:    alpha = v;
                REG_FREQUENCY:    beta = v;
                REG_PHASE_OFFSET: gamma = v;
                REG_LEVEL_OFFSET: delta = v;
                default: ;
            endcase
        endfunction

        static function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        static function longint sat32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // sine and cosine in Q2.30 of a turn fraction
        static function void rotate(logic [31:0] u, output longint sn, output longint cs);
            longint rx, ry, rz, dx, dy;
            logic [63:0] r;
            r = 64'(u[29:0]) * 64'd6746518852;
            rz = longint'(r >> 32);
            rx = 652032874;
            ry = 0;
            for (int i = 0; i < 24; i++) begin
                dx = ry >>> i;
                dy = rx >>> i;
                if (rz >= 0) begin
                    rx -= dx; ry += dy; rz -= longint'(cordic_atan(i));
                end else begin
                    rx += dx; ry -= dy; rz += longint'(cordic_atan(i));
                end
            end
            case (u[31:30])
                2'd0: begin sn = ry; cs = rx; end
                2'd1: begin sn = rx; cs = -ry; end
                2'd2: begin sn = -ry; cs = -rx; end
                default: begin sn = -rx; cs = ry; end
            endcase
        endfunction

        function void note_index(logic [15:0] idx);
            t_point p;
            longint len, xv, ang, sn, cs, yv, t, f;
            logic [63:0] mag;
            logic [127:0] prod;
            logic [31:0] u;
            p.x = 0; p.y = 0; p.last = 0; p.status = ST_OK;
            len = longint'($signed(length));
            if (npoints == 0 || npoints > 17'd65536 || len <= 0) begin
                p.status = ST_BAD_CFG;
            end else if (17'(idx) >= npoints) begin
                p.status = ST_RANGE;
            end else begin
                xv = 0;
                if (npoints > 1) xv = (longint'(idx) * len) / longint'(npoints - 1);
                ang = longint'($signed(beta)) * xv + longint'($signed(gamma)) * 65536;
                mag = (ang < 0) ? -ang : ang;
                prod = 128'(mag) * 128'(64'h28BE60DB9391054A);
                u = prod[95:64];
                if (ang < 0) u = -u;
                rotate(u, sn, cs);
                if (mode == MODE_SIN || mode == MODE_COS) begin
                    f = (mode == MODE_SIN) ? sn : cs;
                    yv = floor_shift(longint'($signed(alpha)) * f, 30);
                end else begin
                    if (cs == 0) begin
                        t = (sn < 0) ? -64'sd2147483648 : 64'sd2147483647;
                        p.status = ST_TAN_SAT;
                    end else begin
                        t = (sn * 65536) / cs;
                        if (t != sat32(t)) begin
                            t = sat32(t);
                            p.status = ST_TAN_SAT;
                        end
                    end
                    yv = floor_shift(longint'($signed(alpha)) * t, 16);
                end
                yv = sat32(yv + longint'($signed(delta)));
                p.x = xv[31:0];
                p.y = yv[31:0];
                p.last = (17'(idx) == npoints - 1);
            end
            pending.push_back(p);
        endfunction

        function void check_point(logic [31:0] x, logic [31:0] y, logic last,
                                  logic [1:0] st);
            t_point e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected item x=%h y=%h", $time, x, y);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (x !== e.x) begin
                $display("%0t: x_coord expected %h actual %h", $time, e.x, x); errors++;
            end
            if (y !== e.y) begin
                $display("%0t: y_value expected %h actual %h", $time, e.y, y); errors++;
            end
            if (last !== e.last) begin
                $display("%0t: is_last expected %b actual %b", $time, e.last, last); errors++;
            end
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic [15:0] i_sample_index = 0;
    logic        i_out_stall = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic        o_in_stall, o_out_valid, o_is_last, pready;
    logic [31:0] o_x_coord, o_y_value, prdata;
    logic [1:0]  o_status;

    point_board board;
    int         max_out_gap = 12;

    always #10 i_clk = ~i_clk;

    trig_waveform_sample_generator_core dut (.*);

    // receiver side: random stalls, check on acceptance
    initial begin
        int gap;
        gap = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                board.check_point(o_x_coord, o_y_value, o_is_last, o_status);
                gap = $urandom_range(0, max_out_gap);
            end
            if (gap > 0) begin
                i_out_stall <= 1;
                gap--;
            end else begin
                i_out_stall <= 0;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        board.write_reg(idx, v);
        @(posedge i_clk);
    endtask

    // sends one index after a random gap, valid stays high between back-to-back items
    task automatic send_index(logic [15:0] idx, int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_sample_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        board.note_index(idx);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
    endtask

    // random index mostly within the line, sometimes past its end
    function automatic logic [15:0] pick_index();
        int unsigned lim;
        lim = (board.npoints == 0) ? 1 : board.npoints;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        if (lim > 65536) lim = 65536;
        return 16'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'($urandom_range(0, 4 * 65536));
            3: return -32'($urandom_range(0, 4 * 65536));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        board = new();
        board.load_defaults();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: defaults, extremes, all functions, special cases
        send_index(16'd0, 0);
        send_index(16'd1, 0);
        send_index(16'd2, 0);
        send_index(16'hFFFF, 0);
        drain();
        reg_write(REG_POINT_COUNT, 32'd1);
        send_index(16'd0, 0);
        send_index(16'd1, 0);
        drain();
        reg_write(REG_POINT_COUNT, 32'd65536);
        reg_write(REG_LINE_LENGTH, 32'h7FFFFFFF);
        reg_write(REG_FREQUENCY, 32'h80000000);
        reg_write(REG_PHASE_OFFSET, 32'h7FFFFFFF);
        reg_write(REG_AMPLITUDE, 32'h7FFFFFFF);
        reg_write(REG_LEVEL_OFFSET, 32'h7FFFFFFF);
        for (int m = 0; m < 4; m++) begin
            reg_write(REG_FUNC_MODE, 32'(m));
            send_index(16'hFFFF, 0);
            send_index(16'h0000, 0);
            send_index(16'h5555, 0);
            drain();
        end
        // tangent near a pole: phase of pi/2
        reg_write(REG_FREQUENCY, 32'd0);
        reg_write(REG_LEVEL_OFFSET, 32'h80000000);
        reg_write(REG_PHASE_OFFSET, 32'd102944);
        send_index(16'd3, 0);
        drain();
        reg_write(REG_PHASE_OFFSET, 32'd102943);
        send_index(16'd3, 0);
        drain();
        // bad configurations
        reg_write(REG_POINT_COUNT, 32'd0);
        send_index(16'd0, 0);
        drain();
        reg_write(REG_POINT_COUNT, 32'h1FFFF);
        send_index(16'd0, 0);
        drain();
        reg_write(REG_POINT_COUNT, 32'd100);
        reg_write(REG_LINE_LENGTH, 32'd0);
        send_index(16'd0, 0);
        drain();
        reg_write(REG_LINE_LENGTH, 32'h80000000);
        send_index(16'd5, 0);
        drain();

        // random phases, each with a fresh setting
        for (int ph = 0; ph < 26; ph++) begin
            int sel;
            sel = $urandom_range(0, 19);
            reg_write(REG_FUNC_MODE, 32'($urandom_range(0, 3)));
            if (sel == 0) reg_write(REG_POINT_COUNT, 32'($urandom_range(0, 3)) << 15 | 32'h10000);
            else if (sel < 4) reg_write(REG_POINT_COUNT, 32'($urandom_range(0, 65536)));
            else reg_write(REG_POINT_COUNT, 32'($urandom_range(1, 200)));
            reg_write(REG_LINE_LENGTH, (sel == 1) ? pick_word() :
                      32'($urandom_range(1, 32'h7FFFFFFF)));
            reg_write(REG_AMPLITUDE, pick_word());
            reg_write(REG_FREQUENCY, pick_word());
            reg_write(REG_PHASE_OFFSET, pick_word());
            reg_write(REG_LEVEL_OFFSET, pick_word());
            max_out_gap = (ph % 4 == 0) ? 0 : 12;
            for (int k = 0; k < 50; k++)
                send_index(pick_index(), (ph % 4 == 1) ? 0 : 12);
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
